>>> sv/wsmm_pkg.sv
// ----------------------------------------------------------------------------
// wsmm_pkg
// Shared constants, types and codes of the waveform store with min/max columns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package wsmm_pkg;

  localparam int unsigned SAMPLES   = 8192;
  localparam int unsigned ADDR_W    = $clog2(SAMPLES);
  localparam int unsigned CNT_W     = ADDR_W + 1;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned WID_W     = 13;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned PIX_W     = 21;
  localparam int unsigned CFG_W     = 14;
  localparam int unsigned MUL_A_W   = VAL_W;
  localparam int unsigned MUL_B_W   = CFG_W;
  localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
  localparam int unsigned DVD_W     = 38;
  localparam int unsigned DVS_W     = 17;
  localparam int unsigned DCNT_W    = $clog2(DVD_W + 1);

  localparam logic [VAL_W-1:0] FULL_SCALE = {VAL_W{1'b1}};
  localparam logic [CFG_W-1:0] N_MIN      = 14'd2;
  localparam logic [CFG_W-1:0] N_MAX      = 14'd8192;
  localparam logic [WID_W-1:0] W_MAX      = 13'd4096;
  localparam logic [WID_W-1:0] H_MAX      = 13'd4096;
  localparam logic [PIX_W-1:0] FRAC_ONE   = 21'd256;
  localparam logic [DVD_W-1:0] HALF_FULL  = 38'd32767;

  localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] REG_WIDTH_PX     = 2'd1;
  localparam logic [1:0] REG_HEIGHT_PX    = 2'd2;

  localparam logic CMD_WRITE_SEG = 1'b0;
  localparam logic CMD_READ_COL  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEG_PREP,
    ST_SEG_DIV,
    ST_SEG_WAIT,
    ST_SEG_RUN,
    ST_POINT,
    ST_RD_MUL,
    ST_RD_DIVLO,
    ST_RD_WAITLO,
    ST_RD_DIVHI,
    ST_RD_WAITHI,
    ST_RD_SCAN,
    ST_RD_DRAIN,
    ST_RD_MULTOP,
    ST_RD_DIVTOP,
    ST_RD_WAITTOP,
    ST_RD_MULBAR,
    ST_RD_DIVBAR,
    ST_RD_WAITBAR,
    ST_RD_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_SEG_PREP,
    OP_POINT,
    OP_DIV_SEG,
    OP_SEG_SETUP,
    OP_SEG_RUN,
    OP_MUL_PX,
    OP_DIV_LO,
    OP_START_CAP,
    OP_DIV_HI,
    OP_END_CAP,
    OP_SCAN,
    OP_MUL_TOP,
    OP_MUL_BAR,
    OP_DIV_SCALE,
    OP_TOP_CAP,
    OP_BAR_CAP,
    OP_OUT_LOAD
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic seg_zero;
    logic seg_last;
    logic scan_last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/wsmm_div.sv
// ----------------------------------------------------------------------------
// wsmm_div
// Restoring divider, one quotient bit per cycle, results held after done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsmm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [wsmm_pkg::DVD_W-1:0]  dividend_i,
  input  logic [wsmm_pkg::DVS_W-1:0]  divisor_i,
  output logic [wsmm_pkg::DVD_W-1:0]  quotient_o,
  output logic [wsmm_pkg::DVS_W-1:0]  remainder_o,
  output logic                        done_o
);
  import wsmm_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0]  dvd_q, dvd_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], fits};
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign done_o      = done_q;

endmodule

`default_nettype wire

>>> sv/wsmm_datapath.sv
// ----------------------------------------------------------------------------
// wsmm_datapath
// Sample store, configuration, segment stepper, window scan and scaling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsmm_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wsmm_pkg::cmd_t               cmd_i,
  output wsmm_pkg::sts_t               sts_o,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [wsmm_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic [wsmm_pkg::ADDR_W-1:0]  first_index_i,
  input  logic [wsmm_pkg::VAL_W-1:0]   first_value_i,
  input  logic [wsmm_pkg::ADDR_W-1:0]  second_index_i,
  input  logic [wsmm_pkg::VAL_W-1:0]   second_value_i,
  input  logic [wsmm_pkg::COL_W-1:0]   column_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wsmm_pkg::VAL_W-1:0]   min_value_o,
  output logic [wsmm_pkg::VAL_W-1:0]   max_value_o,
  output logic [wsmm_pkg::PIX_W-1:0]   top_row_o,
  output logic [wsmm_pkg::PIX_W-1:0]   bar_height_o
);
  import wsmm_pkg::*;

  // configuration
  logic [CFG_W-1:0] n_q;
  logic [WID_W-1:0] w_q, h_q;
  logic [CFG_W-1:0] n_sat, nm1;
  logic [WID_W-1:0] w_sat, h_sat, wm1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= 14'd8192;
      w_q <= 13'd512;
      h_q <= 13'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SAMPLE_COUNT: n_q <= cfg_data_i;
        REG_WIDTH_PX:     w_q <= cfg_data_i[WID_W-1:0];
        REG_HEIGHT_PX:    h_q <= cfg_data_i[WID_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_sat = (n_q < N_MIN) ? N_MIN : ((n_q > N_MAX) ? N_MAX : n_q);
  assign w_sat = (w_q == '0) ? WID_W'(1) : ((w_q > W_MAX) ? W_MAX : w_q);
  assign h_sat = (h_q == '0) ? WID_W'(1) : ((h_q > H_MAX) ? H_MAX : h_q);
  assign nm1   = n_sat - CFG_W'(1);
  assign wm1   = w_sat - WID_W'(1);

  // captured request
  logic [ADDR_W-1:0] fi_q, si_q;
  logic [VAL_W-1:0]  fv_q, sv_q;
  logic [COL_W-1:0]  col_q;

  // segment state
  logic [ADDR_W-1:0] a_q, len_q, i_q, r_q, rd_q;
  logic [VAL_W-1:0]  va_q, q_q, absd_q;
  logic              neg_q;
  logic signed [VAL_W+1:0] qd_q;

  // read state
  logic [ADDR_W-1:0] s_q;
  logic [CNT_W-1:0]  end_q;
  logic [VAL_W-1:0]  mn_q, mx_q, rdata_q;
  logic              rv_q;
  logic [PIX_W-1:0]  top_w_q, bar_w_q;
  logic [PROD_W-1:0] prod_q;

  // outputs
  logic              out_valid_q;
  logic [VAL_W-1:0]  out_min_q, out_max_q;
  logic [PIX_W-1:0]  out_top_q, out_bar_q;

  logic [ADDR_W-1:0] clr_q;

  // divider
  logic              div_start;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DVS_W-1:0]  div_dvs, div_r;
  logic              div_done;

  wsmm_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dvd),
    .divisor_i   (div_dvs),
    .quotient_o  (div_q),
    .remainder_o (div_r),
    .done_o      (div_done)
  );

  logic [PROD_W-1:0] prod_hi;
  assign prod_hi = prod_q + PROD_W'(n_sat);

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (cmd_i.op)
      OP_DIV_SEG: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(absd_q);
        div_dvs   = DVS_W'(len_q);
      end
      OP_DIV_LO: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_q);
        div_dvs   = DVS_W'(w_sat);
      end
      OP_DIV_HI: begin
        div_start = 1'b1;
        div_dvd   = DVD_W'(prod_hi);
        div_dvs   = DVS_W'(w_sat);
      end
      default: ;
    endcase
  end

  // divide by full scale: estimate from shifted sums, low by at most one,
  // then one compare and correct, with estimate and result each registered
  logic             scl_start;
  logic             scl_v1_q, scl_v2_q, scl_done_q;
  logic [DVD_W-1:0] scl_x_q, scl_est_q, scl_res_q;
  logic [DVD_W-1:0] scl_est, scl_rem;

  assign scl_start = cmd_i.op == OP_DIV_SCALE;
  assign scl_est   = (scl_x_q + (scl_x_q >> VAL_W) + (scl_x_q >> (2 * VAL_W))) >> VAL_W;
  assign scl_rem   = scl_x_q - ((scl_est_q << VAL_W) - scl_est_q);

  // shared multiplier, registered
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [COL_W-1:0]   px_c;

  assign px_c = ({1'b0, col_q} > wm1) ? wm1[COL_W-1:0] : col_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_MUL_PX: begin
        mul_a = MUL_A_W'(px_c);
        mul_b = n_sat;
      end
      OP_MUL_TOP: begin
        mul_a = FULL_SCALE - mx_q;
        mul_b = MUL_B_W'(h_sat);
      end
      OP_MUL_BAR: begin
        mul_a = mx_q - mn_q;
        mul_b = MUL_B_W'(h_sat);
      end
      default: ;
    endcase
  end

  // segment preparation
  logic [ADDR_W-1:0] ac, bc;
  logic              swap;
  assign ac   = ({1'b0, fi_q} > nm1) ? nm1[ADDR_W-1:0] : fi_q;
  assign bc   = ({1'b0, si_q} > nm1) ? nm1[ADDR_W-1:0] : si_q;
  assign swap = ac > bc;

  logic [VAL_W-1:0] va_n, vb_n;
  assign va_n = swap ? sv_q : fv_q;
  assign vb_n = swap ? fv_q : sv_q;

  // step increment from divider, floor semantics for a falling segment
  logic                    rnz;
  logic [ADDR_W-1:0]       rem_s;
  logic signed [VAL_W+1:0] qd_n;
  logic [ADDR_W-1:0]       rd_n;
  assign rem_s = div_r[ADDR_W-1:0];
  assign rnz   = rem_s != '0;
  always_comb begin
    if (neg_q) begin
      qd_n = $signed(18'd0) - $signed({2'b00, div_q[VAL_W-1:0]})
             - $signed({17'd0, rnz});
      rd_n = rnz ? (len_q - rem_s) : '0;
    end else begin
      qd_n = $signed({2'b00, div_q[VAL_W-1:0]});
      rd_n = rem_s;
    end
  end

  logic [ADDR_W:0]         r_sum;
  logic                    carry;
  logic signed [VAL_W+1:0] q_sum;
  logic [ADDR_W-1:0]       r_next;
  assign r_sum  = {1'b0, r_q} + {1'b0, rd_q};
  assign carry  = r_sum >= {1'b0, len_q};
  assign r_next = carry ? ADDR_W'(r_sum - {1'b0, len_q}) : r_sum[ADDR_W-1:0];
  assign q_sum  = $signed({2'b00, q_q}) + qd_q + $signed({17'd0, carry});

  // window end
  logic [CNT_W-1:0] end_raw, end_c, end_n;
  assign end_raw = div_q[CNT_W-1:0] + CNT_W'(div_r != '0);
  assign end_c   = (end_raw > n_sat) ? n_sat : end_raw;
  always_comb begin
    end_n = end_c;
    if (end_c <= {1'b0, s_q}) begin
      end_n = (({1'b0, s_q} + CNT_W'(1)) < n_sat) ? ({1'b0, s_q} + CNT_W'(1)) : n_sat;
    end
  end

  // bar floor
  logic [PIX_W-1:0] bar_n;
  always_comb begin
    bar_n = (mx_q > mn_q) ? scl_res_q[PIX_W-1:0] : '0;
    if (bar_n < FRAC_ONE) bar_n = FRAC_ONE;
  end

  // store
  logic [VAL_W-1:0]  mem [SAMPLES];
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [VAL_W-1:0]  wdata;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
      end
      OP_POINT: begin
        we    = 1'b1;
        waddr = a_q;
        wdata = va_q;
      end
      OP_SEG_RUN: begin
        we    = 1'b1;
        waddr = a_q + i_q;
        wdata = q_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[s_q];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
      scl_v1_q    <= 1'b0;
      scl_v2_q    <= 1'b0;
      scl_done_q  <= 1'b0;
    end else begin
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      rv_q       <= cmd_i.op == OP_SCAN;
      scl_v1_q   <= scl_start;
      scl_v2_q   <= scl_v1_q;
      scl_done_q <= scl_v2_q;
      if (cmd_i.op == OP_OUT_LOAD) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rv_q) begin
      if (rdata_q < mn_q) mn_q <= rdata_q;
      if (rdata_q > mx_q) mx_q <= rdata_q;
    end
    if (scl_start) scl_x_q <= DVD_W'({prod_q, 8'd0}) + HALF_FULL;
    if (scl_v1_q) scl_est_q <= scl_est;
    if (scl_v2_q) scl_res_q <= scl_est_q + DVD_W'(scl_rem >= DVD_W'(FULL_SCALE));
    case (cmd_i.op)
      OP_CAPTURE: begin
        fi_q  <= first_index_i;
        fv_q  <= first_value_i;
        si_q  <= second_index_i;
        sv_q  <= second_value_i;
        col_q <= column_i;
      end
      OP_SEG_PREP: begin
        a_q    <= swap ? bc : ac;
        len_q  <= swap ? (ac - bc) : (bc - ac);
        va_q   <= va_n;
        neg_q  <= vb_n < va_n;
        absd_q <= (vb_n < va_n) ? (va_n - vb_n) : (vb_n - va_n);
      end
      OP_SEG_SETUP: begin
        qd_q <= qd_n;
        rd_q <= rd_n;
        q_q  <= va_q;
        r_q  <= len_q >> 1;
        i_q  <= '0;
      end
      OP_SEG_RUN: begin
        q_q <= q_sum[VAL_W-1:0];
        r_q <= r_next;
        i_q <= i_q + ADDR_W'(1);
      end
      OP_MUL_PX, OP_MUL_TOP, OP_MUL_BAR: prod_q <= mul_a * mul_b;
      OP_START_CAP: begin
        s_q  <= div_q[ADDR_W-1:0];
        mn_q <= FULL_SCALE;
        mx_q <= '0;
      end
      OP_END_CAP: end_q <= end_n;
      OP_SCAN:    s_q <= s_q + ADDR_W'(1);
      OP_TOP_CAP: top_w_q <= scl_res_q[PIX_W-1:0];
      OP_BAR_CAP: bar_w_q <= bar_n;
      OP_OUT_LOAD: begin
        out_min_q <= mn_q;
        out_max_q <= mx_q;
        out_top_q <= top_w_q;
        out_bar_q <= bar_w_q;
      end
      default: ;
    endcase
  end

  assign sts_o.clear_last = clr_q == ADDR_W'(SAMPLES - 1);
  assign sts_o.seg_zero   = len_q == '0;
  assign sts_o.seg_last   = i_q == len_q;
  assign sts_o.scan_last  = {1'b0, s_q} == (end_q - CNT_W'(1));
  assign sts_o.div_done   = div_done | scl_done_q;
  assign sts_o.out_busy   = out_valid_q;

  assign out_valid_o  = out_valid_q;
  assign min_value_o  = out_min_q;
  assign max_value_o  = out_max_q;
  assign top_row_o    = out_top_q;
  assign bar_height_o = out_bar_q;

endmodule

`default_nettype wire

>>> sv/wsmm_ctrl.sv
// ----------------------------------------------------------------------------
// wsmm_ctrl
// Sequencer for store clearing, segment writes and column reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module wsmm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            command_i,
  output wsmm_pkg::cmd_t  cmd_o,
  input  wsmm_pkg::sts_t  sts_i
);
  import wsmm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:      if (sts_i.clear_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (command_i == CMD_READ_COL) ? ST_RD_MUL : ST_SEG_PREP;
        end
      end
      ST_SEG_PREP:   state_d = ST_SEG_DIV;
      ST_SEG_DIV:    state_d = sts_i.seg_zero ? ST_POINT : ST_SEG_WAIT;
      ST_SEG_WAIT:   if (sts_i.div_done) state_d = ST_SEG_RUN;
      ST_SEG_RUN:    if (sts_i.seg_last) state_d = ST_IDLE;
      ST_POINT:      state_d = ST_IDLE;
      ST_RD_MUL:     state_d = ST_RD_DIVLO;
      ST_RD_DIVLO:   state_d = ST_RD_WAITLO;
      ST_RD_WAITLO:  if (sts_i.div_done) state_d = ST_RD_DIVHI;
      ST_RD_DIVHI:   state_d = ST_RD_WAITHI;
      ST_RD_WAITHI:  if (sts_i.div_done) state_d = ST_RD_SCAN;
      ST_RD_SCAN:    if (sts_i.scan_last) state_d = ST_RD_DRAIN;
      ST_RD_DRAIN:   state_d = ST_RD_MULTOP;
      ST_RD_MULTOP:  state_d = ST_RD_DIVTOP;
      ST_RD_DIVTOP:  state_d = ST_RD_WAITTOP;
      ST_RD_WAITTOP: if (sts_i.div_done) state_d = ST_RD_MULBAR;
      ST_RD_MULBAR:  state_d = ST_RD_DIVBAR;
      ST_RD_DIVBAR:  state_d = ST_RD_WAITBAR;
      ST_RD_WAITBAR: if (sts_i.div_done) state_d = ST_RD_OUT;
      ST_RD_OUT:     if (!sts_i.out_busy) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = OP_NONE;
    in_stall_o = state_q != ST_IDLE;
    case (state_q)
      ST_CLEAR:      cmd_o.op = OP_CLEAR;
      ST_IDLE:       if (in_valid_i) cmd_o.op = OP_CAPTURE;
      ST_SEG_PREP:   cmd_o.op = OP_SEG_PREP;
      ST_SEG_DIV:    if (!sts_i.seg_zero) cmd_o.op = OP_DIV_SEG;
      ST_SEG_WAIT:   if (sts_i.div_done) cmd_o.op = OP_SEG_SETUP;
      ST_SEG_RUN:    cmd_o.op = OP_SEG_RUN;
      ST_POINT:      cmd_o.op = OP_POINT;
      ST_RD_MUL:     cmd_o.op = OP_MUL_PX;
      ST_RD_DIVLO:   cmd_o.op = OP_DIV_LO;
      ST_RD_WAITLO:  if (sts_i.div_done) cmd_o.op = OP_START_CAP;
      ST_RD_DIVHI:   cmd_o.op = OP_DIV_HI;
      ST_RD_WAITHI:  if (sts_i.div_done) cmd_o.op = OP_END_CAP;
      ST_RD_SCAN:    cmd_o.op = OP_SCAN;
      ST_RD_MULTOP:  cmd_o.op = OP_MUL_TOP;
      ST_RD_DIVTOP:  cmd_o.op = OP_DIV_SCALE;
      ST_RD_WAITTOP: if (sts_i.div_done) cmd_o.op = OP_TOP_CAP;
      ST_RD_MULBAR:  cmd_o.op = OP_MUL_BAR;
      ST_RD_DIVBAR:  cmd_o.op = OP_DIV_SCALE;
      ST_RD_WAITBAR: if (sts_i.div_done) cmd_o.op = OP_BAR_CAP;
      ST_RD_OUT:     if (!sts_i.out_busy) cmd_o.op = OP_OUT_LOAD;
      default:       cmd_o.op = OP_NONE;
    endcase
  end

  // divider results only land while a wait state expects them
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_SEG_WAIT || state_q == ST_RD_WAITLO ||
                        state_q == ST_RD_WAITHI || state_q == ST_RD_WAITTOP ||
                        state_q == ST_RD_WAITBAR))
    else $error("divider finished outside a wait state");

  // a result is never loaded over one not yet taken
  a_no_out_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_OUT_LOAD) |-> !sts_i.out_busy)
    else $error("output register overwritten");

  // an accepted request always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i) |=> (state_q != ST_IDLE))
    else $error("request accepted without starting work");

  // no request is taken during the clearing pass
  a_clear_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> in_stall_o)
    else $error("request taken during clearing pass");

endmodule

`default_nettype wire

>>> sv/waveform_store_minmax_columns_top.sv
// ----------------------------------------------------------------------------
// waveform_store_minmax_columns_top
// Waveform sample store with segment drawing and min/max column summaries.
// ----------------------------------------------------------------------------
// after reset a clearing pass zeroes all 8192 samples while the input is stalled
// segment write: after clamping, a divider run and then one store write per sample
//   from first to second index; a point skips the divider and writes one sample
// column read: two divider runs, two scaling steps and one store read per sample
//   of the window, and a wait while the output stalls
// one request at a time; a finished result waits in the output register
`timescale 1ns / 1ps
`default_nettype none

module waveform_store_minmax_columns_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [wsmm_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          command_i,
  input  logic [wsmm_pkg::ADDR_W-1:0]   first_index_i,
  input  logic [wsmm_pkg::VAL_W-1:0]    first_value_i,
  input  logic [wsmm_pkg::ADDR_W-1:0]   second_index_i,
  input  logic [wsmm_pkg::VAL_W-1:0]    second_value_i,
  input  logic [wsmm_pkg::COL_W-1:0]    column_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wsmm_pkg::VAL_W-1:0]    min_value_o,
  output logic [wsmm_pkg::VAL_W-1:0]    max_value_o,
  output logic [wsmm_pkg::PIX_W-1:0]    top_row_o,
  output logic [wsmm_pkg::PIX_W-1:0]    bar_height_o
);
  import wsmm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  wsmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  wsmm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .first_index_i  (first_index_i),
    .first_value_i  (first_value_i),
    .second_index_i (second_index_i),
    .second_value_i (second_value_i),
    .column_i       (column_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .min_value_o    (min_value_o),
    .max_value_o    (max_value_o),
    .top_row_o      (top_row_o),
    .bar_height_o   (bar_height_o)
  );

endmodule

`default_nettype wire
